FILE: rtl/lrr_pkg.sv
// ---------------------------------------------------------------------------
// lrr_pkg: shared definitions for the ranged random generator
// Constants of the congruential generator, field widths and the command and
// status groups passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package lrr_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned RawW   = 31;
	localparam int unsigned CntW   = 5;

	localparam logic [WordW-1:0] LcgMul = 32'd1103515245;
	localparam logic [WordW-1:0] LcgAdd = 32'd12345;

	// Last counter value of the generator steps in one raw draw and of the divider iterations.
	localparam logic [CntW-1:0] LcgLast = 5'd2;
	localparam logic [CntW-1:0] DivLast = 5'(RawW - 1);

	typedef struct packed {
		logic load_in;    // capture the accepted input word
		logic setup;      // form range and base, clear the remainder
		logic lcg_step;   // advance the generator one step
		logic lcg_first;  // first step of a draw: seed if needed, start raw value
		logic div_step;   // one restoring division iteration
		logic out_load;   // load the result register
	} lrr_cmd_t;

	typedef struct packed {
		logic range_zero;
	} lrr_status_t;

endpackage

FILE: rtl/lcg_ranged_random.sv
// ---------------------------------------------------------------------------
// lcg_ranged_random: ranged pseudo-random number generator
// Draws 31 bits from three steps of a 32-bit linear congruential generator
// and reduces them to a requested range with an iterative remainder unit.
// ---------------------------------------------------------------------------
// Usage:
// Each word on the slave stream requests one value. s_tuser selects the mode:
// 0 returns a value below bound_a (0 when bound_a is 0), 1 returns a value
// between the two bounds, the smaller one included and the larger excluded
// (the bound itself when both are equal). One result word leaves on the
// master stream for every accepted word, in order.
// The cfg channel writes the seed, which is used by the first generator step
// of the first draw after reset; later writes have no effect, as reset sets
// the seed back to 1. cfg_ready is always high.
// From acceptance, a draw passes through setup, three generator steps, 31
// remainder iterations and the output load before m_tvalid rises; a zero
// range goes from setup straight to the output load. The 31 one-bit remainder
// iterations make up most of a draw. One item is handled at a time: a new word
// is accepted once the previous result has entered the output register.
// If the receiver stalls, that result waits there and the next item is
// computed, then held until the register is free.
// Reset clears the generator to 1, the seed to 1 and empties the output.
// ---------------------------------------------------------------------------
module lcg_ranged_random (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,     // seed_value
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,      // [31:0] bound_a, [63:32] bound_b
	input  logic        s_tuser,      // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata       // [31:0] value
);

	lrr_pkg::lrr_cmd_t    cmd;
	lrr_pkg::lrr_status_t status;

	assign cfg_ready = 1'b1;

	lrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lrr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_mode    (s_tuser),
		.in_bound_a (s_tdata[31:0]),
		.in_bound_b (s_tdata[63:32]),
		.out_value  (m_tdata)
	);

endmodule

FILE: rtl/lrr_ctrl.sv
// ---------------------------------------------------------------------------
// lrr_ctrl: sequencer of the ranged random generator
// Walks one item through setup, three generator steps, division iterations
// and output load (no draw for a zero range); handles both stream handshakes.
// ---------------------------------------------------------------------------
module lrr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  lrr_pkg::lrr_status_t status,
	output lrr_pkg::lrr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_LCG,
		S_DIV,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [lrr_pkg::CntW-1:0]  cnt_q;
	logic                      s_tready_q;
	logic                      m_tvalid_q;
	logic                      accept;
	logic                      out_free;

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;
	assign accept   = s_tvalid && s_tready_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd           = '0;
		cmd.load_in   = accept;
		cmd.setup     = (state_q == S_SETUP);
		cmd.lcg_step  = (state_q == S_LCG);
		cmd.lcg_first = (state_q == S_LCG) && (cnt_q == '0);
		cmd.div_step  = (state_q == S_DIV);
		cmd.out_load  = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						s_tready_q <= 1'b0;
						state_q    <= S_SETUP;
					end
				end
				S_SETUP: begin
					cnt_q <= '0;
					// A zero range skips the draw entirely and leaves the generator state alone.
					if (status.range_zero) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_LCG;
					end
				end
				S_LCG: begin
					if (cnt_q == lrr_pkg::LcgLast) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == lrr_pkg::DivLast) begin
						cnt_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						s_tready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/lrr_dp.sv
// ---------------------------------------------------------------------------
// lrr_dp: datapath of the ranged random generator
// Holds the seed and generator state, the congruential multiplier, the raw
// draw register, a restoring remainder unit and the result register.
// ---------------------------------------------------------------------------
module lrr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lrr_pkg::lrr_cmd_t            cmd,
	output lrr_pkg::lrr_status_t         status,
	input  logic                         cfg_valid,
	input  logic [lrr_pkg::WordW-1:0]    cfg_data,
	input  logic                         in_mode,
	input  logic [lrr_pkg::WordW-1:0]    in_bound_a,
	input  logic [lrr_pkg::WordW-1:0]    in_bound_b,
	output logic [lrr_pkg::WordW-1:0]    out_value
);

	logic [lrr_pkg::WordW-1:0] seed_q;
	logic                      seeded_q;
	logic [lrr_pkg::WordW-1:0] gen_q;
	logic                      mode_q;
	logic [lrr_pkg::WordW-1:0] bound_a_q;
	logic [lrr_pkg::WordW-1:0] bound_b_q;
	logic [lrr_pkg::WordW-1:0] range_q;
	logic [lrr_pkg::WordW-1:0] base_q;
	logic [lrr_pkg::RawW-1:0]  raw_q;
	logic [lrr_pkg::WordW-1:0] rem_q;
	logic [lrr_pkg::WordW-1:0] value_q;

	logic [lrr_pkg::WordW-1:0] setup_range;
	logic [lrr_pkg::WordW-1:0] lcg_src;
	logic [lrr_pkg::WordW-1:0] lcg_next;
	logic [lrr_pkg::WordW:0]   rem_shift;
	logic [lrr_pkg::WordW:0]   rem_diff;

	// The range is formed from the held request so the controller can branch during setup.
	always_comb begin
		if (!mode_q) begin
			setup_range = bound_a_q;
		end else if (bound_a_q > bound_b_q) begin
			setup_range = bound_a_q - bound_b_q;
		end else begin
			setup_range = bound_b_q - bound_a_q;
		end
	end

	assign status.range_zero = (setup_range == '0);
	assign out_value         = value_q;

	// The seed is taken in on the first step of the first draw after reset.
	assign lcg_src  = seeded_q ? gen_q : seed_q;
	assign lcg_next = lcg_src * lrr_pkg::LcgMul + lrr_pkg::LcgAdd;

	assign rem_shift = {rem_q, raw_q[lrr_pkg::RawW-1]};
	assign rem_diff  = rem_shift - {1'b0, range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= 32'd1;
			seeded_q <= 1'b0;
			gen_q    <= 32'd1;
		end else begin
			if (cfg_valid) begin
				seed_q <= cfg_data;
			end
			if (cmd.lcg_step) begin
				gen_q <= lcg_next;
				if (cmd.lcg_first) begin
					seeded_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q    <= in_mode;
			bound_a_q <= in_bound_a;
			bound_b_q <= in_bound_b;
		end
		if (cmd.setup) begin
			rem_q   <= '0;
			range_q <= setup_range;
			if (!mode_q) begin
				base_q <= '0;
			end else if (bound_a_q > bound_b_q) begin
				base_q <= bound_b_q;
			end else begin
				base_q <= bound_a_q;
			end
		end
		if (cmd.lcg_step) begin
			if (cmd.lcg_first) begin
				raw_q <= {20'd0, lcg_next[26:16]};
			end else begin
				raw_q <= {raw_q[20:0], lcg_next[25:16]};
			end
		end
		if (cmd.div_step) begin
			raw_q <= {raw_q[lrr_pkg::RawW-2:0], 1'b0};
			if (!rem_diff[lrr_pkg::WordW]) begin
				rem_q <= rem_diff[lrr_pkg::WordW-1:0];
			end else begin
				rem_q <= rem_shift[lrr_pkg::WordW-1:0];
			end
		end
		if (cmd.out_load) begin
			// The remainder stays zero when the range is zero, so the base alone comes out.
			value_q <= base_q + rem_q;
		end
	end

endmodule

FILE: dv/lrr_value_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrr_value_checker: result predictor and comparator for lcg_ranged_random
// Follows the seed register and the generator state, predicts the value for
// every accepted request word and compares it with the result words in order.
// ---------------------------------------------------------------------------
module lrr_value_checker
	import lrr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [WordW-1:0] cfg_data,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [63:0]      s_tdata,
	input  logic             s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [WordW-1:0] m_tdata,
	output int               fail_count,
	output int               pending_count
);

	localparam int ReportMax = 10;

	typedef struct packed {
		logic [WordW-1:0] value;
		logic             drew;
		logic [WordW-1:0] state;
	} draw_result_t;

	logic [WordW-1:0] seed_reg;
	logic [WordW-1:0] gen_state;
	logic             seeded;
	logic [WordW-1:0] expected_values[$];
	int               mismatches;

	function automatic logic [WordW-1:0] lcg_advance(input logic [WordW-1:0] s);
		return s * LcgMul + LcgAdd;
	endfunction

	function automatic draw_result_t predict_value(input logic mode,
			input logic [WordW-1:0] a, input logic [WordW-1:0] b,
			input logic [WordW-1:0] st);
		logic [WordW-1:0] lo;
		logic [WordW-1:0] span;
		logic [WordW-1:0] s1;
		logic [WordW-1:0] s2;
		logic [WordW-1:0] s3;
		logic [WordW-1:0] raw;
		draw_result_t     r;
		if (!mode) begin
			lo = '0;
			span = a;
		end else if (a > b) begin
			lo = b;
			span = a - b;
		end else begin
			lo = a;
			span = b - a;
		end
		r.drew = (span != '0);
		r.state = st;
		// An empty range makes no draw: 0 in mode 0, the common bound in mode 1.
		if (span == '0) begin
			r.value = mode ? b : '0;
		end else begin
			s1 = lcg_advance(st);
			s2 = lcg_advance(s1);
			s3 = lcg_advance(s2);
			raw = {1'b0, s1[26:16], s2[25:16], s3[25:16]};
			r.value = lo + raw % span;
			r.state = s3;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		draw_result_t     pred;
		logic [WordW-1:0] want;
		if (!arst_n) begin
			seed_reg = 32'd1;
			gen_state = 32'd1;
			seeded = 1'b0;
			expected_values.delete();
			mismatches = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			// The result leaving now always belongs to an older request word.
			if (m_tvalid && m_tready) begin
				if (expected_values.size() == 0) begin
					if (mismatches < ReportMax)
						$display("%0t: result word %h with no request pending", $realtime, m_tdata);
					mismatches++;
				end else begin
					want = expected_values.pop_front();
					if (m_tdata !== want) begin
						if (mismatches < ReportMax)
							$display("%0t: value mismatch: expected %h, got %h",
								$realtime, want, m_tdata);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				seed_reg = cfg_data;
			if (s_tvalid && s_tready) begin
				pred = predict_value(s_tuser, s_tdata[31:0], s_tdata[63:32],
					seeded ? gen_state : seed_reg);
				if (pred.drew) begin
					gen_state = pred.state;
					seeded = 1'b1;
				end
				expected_values.push_back(pred.value);
			end
			fail_count <= mismatches;
			pending_count <= expected_values.size();
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: regression bench for lcg_ranged_random
// Writes seeds around the first draw, sends directed and random range
// requests under changing stall patterns and lets the checker verify values.
// ---------------------------------------------------------------------------
module tb;
	import lrr_pkg::*;

	localparam int HoldCycles = 400;
	localparam int WatchLimit = 5000;
	localparam int DrainGap   = 40;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic [WordW-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic [63:0]      s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tready  = 1'b0;
	logic             cfg_ready;
	logic             s_tready;
	logic             m_tvalid;
	logic [WordW-1:0] m_tdata;

	int fail_count;
	int pending_count;
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int sent_cnt          = 0;
	int hold_left         = 0;
	int hold_idx          = 0;
	int quiet_cycles      = 0;
	int hold_marks[2]     = '{400, 1620};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	lcg_ranged_random uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	lrr_value_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Receiver: random stalls, plus long hold-offs that let the block fill up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_idx < 2 && sent_cnt >= hold_marks[hold_idx]) begin
			m_tready <= 1'b0;
			hold_left <= HoldCycles;
			hold_idx <= hold_idx + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchLimit) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic mode, input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
	endtask

	task automatic random_request;
		logic             mode;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		mode = 1'($urandom_range(1));
		a = $urandom;
		b = $urandom;
		case ($urandom_range(7))
			0: begin
				a = $urandom_range(16);
				b = $urandom_range(16);
			end
			1: begin
				a = 32'hFFFF_FFFF - $urandom_range(16);
				b = 32'hFFFF_FFFF - $urandom_range(16);
			end
			2: b = a;
			3: a = '0;
			4: a = 32'd1 << $urandom_range(31);
			5: b = a ^ $urandom_range(15);
			default: ;
		endcase
		send_request(mode, a, b);
	endtask

	task automatic write_seed(input logic [WordW-1:0] seed);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DrainGap) @(posedge clk);
	endtask

	initial begin
		logic [WordW-1:0] r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 27;
		receiver_idle_pct = 82;

		// Empty ranges before the first draw must not load the seed.
		write_seed(32'h0);
		send_request(1'b0, 32'h0, $urandom);
		send_request(1'b1, 32'h0, 32'h0);
		wait_drained();
		write_seed(32'hFFFF_FFFF);
		r = $urandom;
		send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(1'b1, r, r);
		wait_drained();
		case ($urandom_range(2))
			0: write_seed(32'h0);
			1: write_seed(32'hFFFF_FFFF);
			default: write_seed($urandom);
		endcase

		send_request(1'b0, 32'h1, 32'h0);
		send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(1'b0, 32'h8000_0000, 32'h0);
		send_request(1'b0, 32'h7FFF_FFFF, $urandom);
		send_request(1'b0, 32'h2, $urandom);
		send_request(1'b1, 32'h0, 32'hFFFF_FFFF);
		send_request(1'b1, 32'hFFFF_FFFF, 32'h0);
		send_request(1'b1, 32'h5, 32'h6);
		send_request(1'b1, 32'h6, 32'h5);
		send_request(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_request(1'b0, 32'h0, $urandom);
		r = $urandom;
		send_request(1'b1, r, r);
		send_request(1'b1, 32'h0, 32'h1);
		send_request(1'b0, 32'h3, $urandom);
		send_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();

		// Seeds written from here on must leave the generator alone.
		write_seed(32'h0);
		repeat (600) random_request();
		wait_drained();

		sender_idle_pct = 82;
		receiver_idle_pct = 27;
		write_seed(32'hFFFF_FFFF);
		repeat (600) random_request();
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_seed($urandom);
		repeat (630) random_request();
		wait_drained();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/lrr_pkg.sv
rtl/lrr_ctrl.sv
rtl/lrr_dp.sv
rtl/lcg_ranged_random.sv
dv/lrr_value_checker.sv
dv/tb.sv
